// ===== sv/reb_pkg.sv =====
`default_nettype none
package reb_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned NumRegs  = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DrawLimit = 32;
  localparam int unsigned DrawCntW = $clog2(DrawLimit);

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegSeedFirst   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSeedSecond  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeedThird   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeedFourth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEscZero     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEscPrefix   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCount       = 3'd6;

  localparam byte_t CfgReset [NumRegs] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd193, 8'd248};

  // decoded work for the output side: one or two bytes
  typedef struct packed {
    logic  two;
    byte_t first;
    byte_t second;
  } op_t;

  typedef struct packed {
    logic  load;
    byte_t a;
    byte_t b;
    byte_t c;
    byte_t d;
  } gen_load_t;

  typedef struct packed {
    logic  go;
    byte_t forbid;
  } gen_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    logic  found;
    byte_t code;
  } gen_rsp_t;

endpackage
`default_nettype wire

// ===== sv/reb_gen.sv =====
`default_nettype none
module reb_gen (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire reb_pkg::gen_load_t load_i,
  input  wire reb_pkg::gen_req_t  req_i,
  output reb_pkg::gen_rsp_t       rsp_o
);
  import reb_pkg::*;

  byte_t a_q, b_q, c_q, d_q;
  byte_t forbid_q;
  logic  busy_q, busy_d;
  logic [DrawCntW-1:0] cnt_q, cnt_d;
  byte_t t, nd;
  logic  hit, done;

  // one xorshift step per cycle while a draw runs
  always_comb begin
    t    = a_q ^ (a_q << 3);
    nd   = d_q ^ (d_q >> 5) ^ t ^ (t >> 2);
    hit  = (nd != '0) && (nd != forbid_q);
    done = busy_q && (hit || (cnt_q == DrawCntW'(DrawLimit - 1)));
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load_i.load) begin
      busy_d = 1'b0;
    end else if (req_i.go) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      busy_d = !done;
      cnt_d  = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= CfgReset[RegSeedFirst];
      b_q    <= CfgReset[RegSeedSecond];
      c_q    <= CfgReset[RegSeedThird];
      d_q    <= CfgReset[RegSeedFourth];
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (load_i.load) begin
        a_q <= load_i.a;
        b_q <= load_i.b;
        c_q <= load_i.c;
        d_q <= load_i.d;
      end else if (busy_q) begin
        a_q <= b_q;
        b_q <= c_q;
        c_q <= d_q;
        d_q <= nd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      forbid_q <= req_i.forbid;
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done;
  assign rsp_o.found = hit;
  assign rsp_o.code  = nd;

endmodule
`default_nettype wire

// ===== sv/reb_front.sv =====
`default_nettype none
module reb_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire reb_pkg::byte_t                in_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [reb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire reb_pkg::byte_t                cfg_data_i,
  output reb_pkg::gen_load_t                 gen_load_o,
  output reb_pkg::gen_req_t                  gen_req_o,
  input  wire reb_pkg::gen_rsp_t             gen_rsp_i,
  output logic                               op_valid_o,
  output reb_pkg::op_t                       op_o,
  input  wire logic                          op_ready_i
);
  import reb_pkg::*;

  byte_t cfg_q [NumRegs];
  byte_t cfg_d [NumRegs];
  logic  reload;
  logic  pending_q, pending_d;
  byte_t zero_esc_q, pre_esc_q;
  logic  draw_zero_q;
  logic  accept;
  logic  is_zero_esc, is_pre_esc, is_end;

  assign in_ready_o  = !gen_rsp_i.busy && op_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_zero_esc = (in_byte_i == zero_esc_q);
  assign is_pre_esc  = (in_byte_i == pre_esc_q);
  assign is_end      = (in_byte_i == '0);

  always_comb begin
    cfg_d  = cfg_q;
    reload = 1'b0;
    if (cfg_we_i && (cfg_idx_i < RegCount)) begin
      cfg_d[cfg_idx_i] = cfg_data_i;
      reload           = 1'b1;
    end
  end

  assign gen_load_o.load = reload;
  assign gen_load_o.a    = cfg_d[RegSeedFirst];
  assign gen_load_o.b    = cfg_d[RegSeedSecond];
  assign gen_load_o.c    = cfg_d[RegSeedThird];
  assign gen_load_o.d    = cfg_d[RegSeedFourth];

  // classify the item; the tests run in priority order
  always_comb begin
    pending_d        = pending_q;
    op_valid_o       = 1'b0;
    op_o.two         = 1'b0;
    op_o.first       = in_byte_i;
    op_o.second      = in_byte_i;
    gen_req_o.go     = 1'b0;
    gen_req_o.forbid = zero_esc_q;
    if (accept) begin
      if (pending_q) begin
        pending_d  = 1'b0;
        op_valid_o = 1'b1;
        priority if (is_zero_esc) begin
          gen_req_o.go     = 1'b1;
          gen_req_o.forbid = pre_esc_q;
        end else if (is_pre_esc) begin
          gen_req_o.go     = 1'b1;
          gen_req_o.forbid = zero_esc_q;
        end else if (is_end) begin
          op_o.first = pre_esc_q;
        end else begin
          op_o.first = pre_esc_q;
          op_o.two   = 1'b1;
        end
      end else begin
        priority if (is_end || is_pre_esc) begin
          pending_d = 1'b1;
        end else if (is_zero_esc) begin
          op_valid_o = 1'b1;
          op_o.first = '0;
        end else begin
          op_valid_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      pending_q   <= 1'b0;
      zero_esc_q  <= CfgReset[RegEscZero];
      pre_esc_q   <= CfgReset[RegEscPrefix];
      draw_zero_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (reload) begin
        pending_q  <= 1'b0;
        zero_esc_q <= cfg_d[RegEscZero];
        pre_esc_q  <= cfg_d[RegEscPrefix];
      end else begin
        pending_q <= pending_d;
        if (gen_rsp_i.done && gen_rsp_i.found) begin
          if (draw_zero_q) begin
            zero_esc_q <= gen_rsp_i.code;
          end else begin
            pre_esc_q <= gen_rsp_i.code;
          end
        end
      end
      if (gen_req_o.go) begin
        draw_zero_q <= is_zero_esc;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/reb_queue.sv =====
`default_nettype none
module reb_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire reb_pkg::op_t  push_op_i,
  output logic               not_full_o,
  input  wire logic          pop_i,
  output reb_pkg::op_t       pop_op_o,
  output logic               not_empty_o
);
  import reb_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t              mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign not_full_o  = (cnt_q != CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign pop_op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/reb_back.sv =====
`default_nettype none
module reb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          op_valid_i,
  input  wire reb_pkg::op_t  op_i,
  output logic               op_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output reb_pkg::byte_t     out_byte_o,
  output logic               out_last_o
);
  import reb_pkg::*;

  logic  out_valid_q;
  byte_t out_byte_q;
  logic  out_last_q;
  logic  second_q;
  byte_t second_byte_q;
  logic  free;

  assign free     = !out_valid_q || out_ready_i;
  assign op_pop_o = free && !second_q && op_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (free) begin
      if (second_q) begin
        out_valid_q <= 1'b1;
        second_q    <= 1'b0;
      end else begin
        out_valid_q <= op_valid_i;
        second_q    <= op_valid_i && op_i.two;
      end
    end
  end

  // hold the second byte of a pair until the first has gone
  always_ff @(posedge clk_i) begin
    if (free) begin
      if (second_q) begin
        out_byte_q <= second_byte_q;
        out_last_q <= 1'b1;
      end else if (op_valid_i) begin
        out_byte_q    <= op_i.first;
        out_last_q    <= !op_i.two;
        second_byte_q <= op_i.second;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== sv/rotating_escape_byte_unstuffer_top.sv =====
`default_nettype none
// Byte unstuffer with two rotating escape codes. Each stuffed byte on the
// slave stream gives zero, one or two plain bytes on the master stream;
// tlast marks the final byte caused by one input item. An item that
// retires an escape code starts a draw of the xorshift generator, one
// step per cycle, during which no input is taken. A two-byte result holds
// the output register until both bytes have gone; a small op queue between
// the decoder and the output register lets the input keep flowing while
// results wait. Any configuration write to a valid index reloads seeds,
// escape codes and the prefix flag; write only while idle.
module rotating_escape_byte_unstuffer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] stuffed_byte
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] plain_byte
  output logic                             m_axis_tlast,
  input  wire logic                        cfg_we_i,
  input  wire logic [reb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]                  cfg_data_i
);
  import reb_pkg::*;

  gen_load_t gen_load;
  gen_req_t  gen_req;
  gen_rsp_t  gen_rsp;
  logic      push, not_full, pop, not_empty;
  op_t       push_op, pop_op;

  reb_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (gen_load),
    .req_i  (gen_req),
    .rsp_o  (gen_rsp)
  );

  reb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .gen_load_o (gen_load),
    .gen_req_o  (gen_req),
    .gen_rsp_i  (gen_rsp),
    .op_valid_o (push),
    .op_o       (push_op),
    .op_ready_i (not_full)
  );

  reb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_op_i   (push_op),
    .not_full_o  (not_full),
    .pop_i       (pop),
    .pop_op_o    (pop_op),
    .not_empty_o (not_empty)
  );

  reb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (not_empty),
    .op_i        (pop_op),
    .op_pop_o    (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_no_input_during_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !gen_rsp.busy)
    else $error("input taken while a draw runs");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> not_full)
    else $error("op queue overflow");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second byte of a pair missing");

  a_draw_starts_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_req.go |-> !gen_rsp.busy)
    else $error("draw started while generator busy");

endmodule
`default_nettype wire

// ===== tb/tb_rotating_escape_byte_unstuffer_top.sv =====
`default_nettype none
module tb_rotating_escape_byte_unstuffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import reb_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  // longest generator draw plus the output pipeline
  localparam int unsigned SettleCycles = DrawLimit + 8;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    byte_t plain;
    logic  last;
  } plain_item_t;

  class unstuff_checker;
    byte_t         regs [NumRegs];
    bit            prefix_pending;
    byte_t         zero_esc;
    byte_t         prefix_esc;
    byte_t         gen_a, gen_b, gen_c, gen_d;
    plain_item_t   expected_plain [$];
    int unsigned   errors;

    function new();
      foreach (regs[i]) regs[i] = CfgReset[i];
      errors = 0;
      reload();
    endfunction

    function void reload();
      gen_a          = regs[RegSeedFirst];
      gen_b          = regs[RegSeedSecond];
      gen_c          = regs[RegSeedThird];
      gen_d          = regs[RegSeedFourth];
      zero_esc       = regs[RegEscZero];
      prefix_esc     = regs[RegEscPrefix];
      prefix_pending = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, byte_t value);
      // indexes past the register file are ignored, no reload
      if (idx < RegCount) begin
        regs[idx] = value;
        reload();
      end
    endfunction

    // step the xorshift until the output word is usable; give up after the limit
    function byte_t draw_escape(byte_t old_code, byte_t forbid);
      byte_t       t;
      int unsigned n;
      for (n = 0; n < DrawLimit; n++) begin
        t     = gen_a ^ byte_t'(gen_a << 3);
        gen_a = gen_b;
        gen_b = gen_c;
        gen_c = gen_d;
        gen_d = gen_d ^ (gen_d >> 5) ^ t ^ (t >> 2);
        if (gen_d != 8'd0 && gen_d != forbid) return gen_d;
      end
      return old_code;
    endfunction

    function void expect_plain(byte_t plain, logic last);
      plain_item_t item;
      item.plain = plain;
      item.last  = last;
      expected_plain.push_back(item);
    endfunction

    function void note_stuffed(byte_t stuffed);
      if (prefix_pending) begin
        prefix_pending = 1'b0;
        if (stuffed == zero_esc) begin
          expect_plain(stuffed, 1'b1);
          zero_esc = draw_escape(zero_esc, prefix_esc);
        end else if (stuffed == prefix_esc) begin
          expect_plain(stuffed, 1'b1);
          prefix_esc = draw_escape(prefix_esc, zero_esc);
        end else if (stuffed == 8'd0) begin
          expect_plain(prefix_esc, 1'b1);
        end else begin
          expect_plain(prefix_esc, 1'b0);
          expect_plain(stuffed, 1'b1);
        end
      end else if (stuffed == 8'd0 || stuffed == prefix_esc) begin
        prefix_pending = 1'b1;
      end else begin
        expect_plain((stuffed == zero_esc) ? 8'd0 : stuffed, 1'b1);
      end
    endfunction

    function void check_plain(byte_t plain, logic last);
      plain_item_t want;
      if (expected_plain.size() == 0) begin
        errors++;
        $display("%0t: unexpected plain byte %h last %b", $time, plain, last);
        return;
      end
      want = expected_plain.pop_front();
      if (want.plain !== plain) begin
        errors++;
        $display("%0t: plain byte expected %h, actual %h", $time, want.plain, plain);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: last expected %b, actual %b", $time, want.last, last);
      end
    endfunction

    function int unsigned outstanding();
      return expected_plain.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'd0;   // [7:0] stuffed_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;           // [7:0] plain_byte
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [7:0]          cfg_data_i    = 8'd0;

  unstuff_checker sb;
  bit             steady = 1'b0;
  int unsigned    cycle_cnt = 0;

  rotating_escape_byte_unstuffer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // output side: check each item taken, stall at random unless steady
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_plain(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 13);
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // valid stays high after acceptance; the next call re-drives or drops it
  task automatic send_stuffed(input byte_t value);
    if (!steady && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_stuffed(value);
  endtask

  // hold the input until all results are out and any draw has finished
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input byte_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic end_cfg();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_all(input byte_t s0, input byte_t s1, input byte_t s2,
                          input byte_t s3, input byte_t e1, input byte_t e2);
    write_cfg(RegSeedFirst,  s0);
    write_cfg(RegSeedSecond, s1);
    write_cfg(RegSeedThird,  s2);
    write_cfg(RegSeedFourth, s3);
    write_cfg(RegEscZero,    e1);
    write_cfg(RegEscPrefix,  e2);
    end_cfg();
  endtask

  // mostly escape codes and end marks so that every decode path is reached
  function automatic byte_t pick_stuffed();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return sb.prefix_esc;
    if (r < 45) return sb.zero_esc;
    if (r < 55) return 8'd0;
    if (r < 60) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  task automatic random_run(input int unsigned count);
    repeat (count) send_stuffed(pick_stuffed());
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: every decode path by hand
    send_stuffed(8'h01);
    send_stuffed(8'hFF);
    send_stuffed(8'h80);
    send_stuffed(sb.zero_esc);
    send_stuffed(8'h00);
    send_stuffed(8'h00);
    send_stuffed(sb.prefix_esc);
    send_stuffed(8'h7F);
    send_stuffed(sb.prefix_esc);
    send_stuffed(sb.zero_esc);
    send_stuffed(sb.prefix_esc);
    send_stuffed(sb.prefix_esc);
    send_stuffed(8'h00);
    send_stuffed(sb.zero_esc);
    send_stuffed(8'h00);
    send_stuffed(8'hFF);
    send_stuffed(sb.prefix_esc);
    send_stuffed(8'h00);
    send_stuffed(8'h55);
    send_stuffed(8'hAA);
    random_run(60);
    drain();
    random_run(60);
    drain();

    // extremes, no idling on either side
    load_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01);
    steady = 1'b1;
    random_run(120);
    drain();
    steady = 1'b0;

    // all-zero generator: every draw runs out and the codes stay
    load_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF);
    send_stuffed(sb.prefix_esc);
    send_stuffed(sb.zero_esc);
    send_stuffed(sb.prefix_esc);
    send_stuffed(sb.prefix_esc);
    random_run(60);
    drain();

    // equal escape codes
    load_all(8'h3C, 8'hA5, 8'h0F, 8'hC3, 8'h5A, 8'h5A);
    random_run(80);
    drain();

    // zero escape codes, and writes past the register file
    load_all(8'h11, 8'h22, 8'h44, 8'h88, 8'h00, 8'h00);
    write_cfg(RegCount, byte_t'($urandom_range(255)));
    write_cfg(RegUnused, byte_t'($urandom_range(255)));
    end_cfg();
    random_run(80);
    drain();

    repeat (3) begin
      load_all(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
               byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
               byte_t'($urandom_range(255, 1)), byte_t'($urandom_range(255, 1)));
      random_run(110);
      drain();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/reb_pkg.sv
sv/reb_gen.sv
sv/reb_front.sv
sv/reb_queue.sv
sv/reb_back.sv
sv/rotating_escape_byte_unstuffer_top.sv
tb/tb_rotating_escape_byte_unstuffer_top.sv
